### hw/rtl/lca_pkg.sv
// Shared types for the Life cellular automaton unit: operation codes and
// controller states. No dependencies; imported by lca_row_rule and the top level.
package lca_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_ADVANCE,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/lca_row_rule.sv
// Next-generation rule for one full grid row, one lane per cell, with wrap
// at the row ends. Depends on lca_pkg.
module lca_row_rule
    import lca_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic [WIDTH-1:0] up,
    input  logic [WIDTH-1:0] mid,
    input  logic [WIDTH-1:0] dn,
    output logic [WIDTH-1:0] next_row
);

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_lane
        localparam int L = (i == 0) ? WIDTH - 1 : i - 1;
        localparam int R = (i == WIDTH - 1) ? 0 : i + 1;
        logic [3:0] count;

        always_comb
        begin
            count = 4'(up[L]) + 4'(up[i]) + 4'(up[R])
                  + 4'(mid[L]) + 4'(mid[R])
                  + 4'(dn[L]) + 4'(dn[i]) + 4'(dn[R]);
            // birth on three, survival on two or three
            next_row[i] = (count == 4'd3) || (mid[i] && (count == 4'd2));
        end
    end

endmodule

### hw/rtl/life_cellular_automaton_unit.sv
// Top level of the toroidal Game of Life unit: row-wide grid memory,
// controller and output register. Depends on lca_pkg and lca_row_rule.
//
// The grid lives in one synchronous memory holding two banks of GRID_SIZE
// rows, each row a GRID_SIZE-bit word; bank_reg marks the bank that holds the
// current generation. After reset the unit clears bank 0 row by row and keeps
// in_stall high meanwhile. It then takes one word at a time. A cell write or
// read goes through a memory read, a row modify/pick and the hand-off into the
// output register before the next word is accepted: a write rewrites the
// whole row it touched. An advance streams the source bank through a three-row
// window at one row per cycle, writes each new row into the other bank and
// then flips bank_reg; its result follows the row reads on the single memory
// read port (last row, every row, row 0 again), the window lag and the
// hand-off into the output register. Cells outside the grid are ignored on
// write and read as zero; unused op codes just return a zero result. The
// result sits in an output register, so the next word is accepted while a
// result still waits.
module life_cellular_automaton_unit
    import lca_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [5:0] row,
    input  logic [5:0] col,
    input  logic       value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       read_value
);

    localparam int RW    = $clog2(GRID_SIZE);
    localparam int CW    = $clog2(GRID_SIZE + 3);
    localparam int DEPTH = 2 ** (RW + 1);

    // grid memory: {bank, row} addressed, one row per word
    logic [GRID_SIZE-1:0] mem [DEPTH];

    state_t               state_reg, state_next;
    logic                 bank_reg, bank_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    op_t                  op_reg;
    logic [RW-1:0]        row_reg;
    logic [RW-1:0]        col_reg;
    logic                 value_reg;
    logic                 res_reg, res_next;
    logic [GRID_SIZE-1:0] rd_data_reg;
    logic [GRID_SIZE-1:0] up_reg;
    logic [GRID_SIZE-1:0] mid_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 read_value_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 in_range;
    logic                 rd_en;
    logic                 rd_bank;
    logic [RW-1:0]        rd_row;
    logic                 wr_en;
    logic                 wr_bank;
    logic [RW-1:0]        wr_row;
    logic [GRID_SIZE-1:0] wr_data;
    logic [GRID_SIZE-1:0] rule_row;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_range   = (32'(row) < GRID_SIZE) && (32'(col) < GRID_SIZE);
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

    lca_row_rule #(
        .WIDTH (GRID_SIZE)
    ) u_rule (
        .up       (up_reg),
        .mid      (mid_reg),
        .dn       (rd_data_reg),
        .next_row (rule_row)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CW'(GRID_SIZE - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_t'(op))
                        OP_WRITE, OP_READ:
                            state_next = in_range ? ST_ACCESS : ST_DONE;
                        OP_ADVANCE:
                            state_next = ST_ADVANCE;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_ACCESS:
                state_next = ST_DONE;
            ST_ADVANCE:
            begin
                if (cnt_reg == CW'(GRID_SIZE + 2))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // memory port controls
    always_comb
    begin
        rd_en   = 1'b0;
        rd_bank = bank_reg;
        rd_row  = RW'(row);
        wr_en   = 1'b0;
        wr_bank = bank_reg;
        wr_row  = row_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_bank = 1'b0;
                wr_row  = RW'(cnt_reg);
                wr_data = '0;
            end
            ST_IDLE:
                rd_en = in_fire && in_range
                     && ((op_t'(op) == OP_WRITE) || (op_t'(op) == OP_READ));
            ST_ACCESS:
            begin
                wr_en            = (op_reg == OP_WRITE);
                wr_data[col_reg] = value_reg;
            end
            ST_ADVANCE:
            begin
                // read order: last row, rows 0..N-1, row 0 again (wrap)
                rd_en = (cnt_reg <= CW'(GRID_SIZE + 1));
                if (cnt_reg == '0)
                    rd_row = RW'(GRID_SIZE - 1);
                else if (cnt_reg == CW'(GRID_SIZE + 1))
                    rd_row = '0;
                else
                    rd_row = RW'(cnt_reg - CW'(1));
                // window is full once cnt_reg reaches 3
                wr_en   = (cnt_reg >= CW'(3));
                wr_bank = !bank_reg;
                wr_row  = RW'(cnt_reg - CW'(3));
                wr_data = rule_row;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // counter, bank, result and output register next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
                cnt_next = (cnt_reg == CW'(GRID_SIZE - 1)) ? '0 : cnt_reg + CW'(1);
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                    res_next = 1'b0;
            end
            ST_ACCESS:
                res_next = (op_reg == OP_READ) && rd_data_reg[col_reg];
            ST_ADVANCE:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(GRID_SIZE + 2))
                    bank_next = !bank_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            bank_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_fire)
        begin
            op_reg    <= op_t'(op);
            row_reg   <= RW'(row);
            col_reg   <= RW'(col);
            value_reg <= value;
        end
        if (state_reg == ST_ADVANCE)
        begin
            up_reg  <= mid_reg;
            mid_reg <= rd_data_reg;
        end
        if ((state_reg == ST_DONE) && out_free)
            read_value_reg <= res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[{rd_bank, rd_row}];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{wr_bank, wr_row}] <= wr_data;
    end

`ifndef SYNTHESIS
    a_adv_flips_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADVANCE && state_next == ST_DONE) |=> bank_reg != $past(bank_reg))
        else $error("advance finished without flipping the bank");

    a_adv_writes_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADVANCE && wr_en) |-> (wr_bank != bank_reg) && (rd_bank == bank_reg))
        else $error("advance touched the wrong bank");

    a_no_same_row_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> ((rd_bank != wr_bank) || (rd_row != wr_row)))
        else $error("read and write of the same row in one cycle");

    a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && op_reg != OP_READ) |-> !res_reg)
        else $error("nonzero result for an op other than read");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for life_cellular_automaton_unit (toroidal Game of Life grid).
// Depends on lca_pkg and the RTL only: it holds its own double-buffered grid predictor,
// walks a directed table, then runs random words under varying valid/stall pressure.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lca_pkg::*;

    localparam int GRID = 64;
    // op code 3 has no package member; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 38;
    localparam int HOLD_CYCLES      = 300;   // long receiver hold-off in the last phase
    localparam int DRAIN_CYCLES     = 20;
    // clear pass, hold-off, one advance and the worst random stall, several times over
    localparam int WATCHDOG_LIMIT   = 3000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] op         = 2'd0;
    logic [5:0] row        = 6'd0;
    logic [5:0] col        = 6'd0;
    logic       value      = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       read_value;

    always #5 clk = ~clk;

    life_cellular_automaton_unit #(
        .GRID_SIZE (GRID)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .row        (row),
        .col        (col),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value)
    );

    // ------------------------------------------------------------------
    // Grid predictor: two banks of GRID rows, cur_bank holds the live
    // generation. Writes and reads hit cur_bank; an advance fills the
    // other bank from cur_bank only, then flips it.
    // ------------------------------------------------------------------
    bit [GRID-1:0] model_grid [2][GRID];
    bit            cur_bank = 1'b0;

    // expected read_value of every accepted word, oldest first
    bit expected_reads [$];

    int mismatch_count = 0;

    function automatic void step_generation();
        int  up;
        int  dn;
        int  lf;
        int  rt;
        int  live;
        bit  src;
        src = cur_bank;
        for (int r = 0; r < GRID; r++)
        begin
            up = (r + GRID - 1) % GRID;
            dn = (r + 1) % GRID;
            for (int c = 0; c < GRID; c++)
            begin
                lf = (c + GRID - 1) % GRID;
                rt = (c + 1) % GRID;
                live = model_grid[src][up][lf] + model_grid[src][up][c]
                     + model_grid[src][up][rt] + model_grid[src][r][lf]
                     + model_grid[src][r][rt]  + model_grid[src][dn][lf]
                     + model_grid[src][dn][c]  + model_grid[src][dn][rt];
                if (!model_grid[src][r][c])
                    model_grid[!src][r][c] = (live == 3);
                else
                    model_grid[!src][r][c] = (live == 2 || live == 3);
            end
        end
        cur_bank = !src;
    endfunction

    function automatic bit predict_read_value(input logic [1:0] p_op, input logic [5:0] p_row,
                                              input logic [5:0] p_col, input logic p_val);
        bit in_grid;
        bit result;
        in_grid = (p_row < GRID) && (p_col < GRID);
        result  = 1'b0;
        case (p_op)
            OP_WRITE:
            begin
                if (in_grid)
                    model_grid[cur_bank][p_row][p_col] = p_val;
            end
            OP_READ:
            begin
                if (in_grid)
                    result = model_grid[cur_bank][p_row][p_col];
            end
            OP_ADVANCE:
                step_generation();
            default: ;
        endcase
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. fixed_exp marks rows whose result is obvious
    // (zero after reset, for writes, advances and the unused op); those
    // rows compare against exp_val, the rest against the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        logic       value;
        bit         fixed_exp;
        bit         exp_val;
    } stim_word_t;

    localparam int N_DIRECTED = 25;
    localparam stim_word_t DIRECTED [N_DIRECTED] = '{
        '{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0},  // grid cleared at reset
        '{OP_READ,    6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_WRITE,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0},  // kill a live cell
        '{OP_READ,    6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_UNUSED,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0},  // must not touch the grid
        '{OP_READ,    6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        // vertical blinker straddling the top/bottom wrap in column 0
        '{OP_WRITE,   6'd63, 6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd1,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_ADVANCE, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
        '{OP_READ,    6'd0,  6'd63, 1'b0, 1'b0, 1'b0},  // left/right wrap
        '{OP_READ,    6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_ADVANCE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd1,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd21, 6'd42, 1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd42, 6'd21, 1'b1, 1'b0, 1'b0},
        '{OP_WRITE,   6'd21, 6'd42, 1'b1, 1'b1, 1'b0},  // lone cell
        '{OP_READ,    6'd21, 6'd42, 1'b0, 1'b0, 1'b0},
        '{OP_ADVANCE, 6'd42, 6'd21, 1'b0, 1'b1, 1'b0},  // lone cell dies
        '{OP_READ,    6'd21, 6'd42, 1'b0, 1'b0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Sender: drives at the falling edge, waits for acceptance at the
    // rising edge, then books the expectation. Valid is only lowered for
    // an idle gap, never dropped and re-raised in one step.
    // ------------------------------------------------------------------
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    task automatic send_word(input logic [1:0] w_op, input logic [5:0] w_row,
                             input logic [5:0] w_col, input logic w_val,
                             input bit w_fixed, input bit w_exp);
        bit predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= w_op;
        row      <= w_row;
        col      <= w_col;
        value    <= w_val;
        do
            @(posedge clk);
        while (in_stall);
        // predictor always runs so its grid tracks the block
        predicted = predict_read_value(w_op, w_row, w_col, w_val);
        expected_reads.push_back(w_fixed ? w_exp : predicted);
        @(negedge clk);
    endtask

    // Random words: most land in a small patch around the corner wrap so
    // that advances see real neighborhoods; the rest spread over the grid.
    task automatic run_random_phase(input int count);
        int         pick;
        logic [1:0] r_op;
        logic [5:0] r_row;
        logic [5:0] r_col;
        logic       r_val;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                r_op = OP_ADVANCE;
            else if (pick < 13)
                r_op = OP_UNUSED;
            else if (pick < 60)
                r_op = OP_WRITE;
            else
                r_op = OP_READ;
            if ($urandom_range(99) < 60)
            begin
                r_row = 6'($urandom_range(7) + 60);
                r_col = 6'($urandom_range(7) + 60);
            end
            else
            begin
                r_row = 6'($urandom_range(63));
                r_col = 6'($urandom_range(63));
            end
            r_val = ($urandom_range(99) < 55);
            send_word(r_op, r_row, r_col, r_val, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall at the falling edge, plus one long hold-off
    // counted here once armed, so the output register and then the input
    // back up while the sender keeps offering words.
    // ------------------------------------------------------------------
    bit rx_hold_armed = 1'b0;
    bit rx_hold_done  = 1'b0;
    int rx_hold_left  = 0;

    always @(negedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            out_stall    <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_armed && !rx_hold_done)
        begin
            out_stall    <= 1'b1;
            rx_hold_left <= HOLD_CYCLES - 1;
            rx_hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual read_value %0b",
                         $time, read_value);
                mismatch_count++;
            end
            else
            begin
                bit exp_bit;
                exp_bit = expected_reads.pop_front();
                if (read_value !== exp_bit)
                begin
                    $display("%0t: read_value mismatch, expected %0b, actual %0b",
                             $time, exp_bit, read_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, no idling; the block's clear pass holds in_stall
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                      DIRECTED[i].value, DIRECTED[i].fixed_exp, DIRECTED[i].exp_val);

        // sender mostly busy, receiver mostly stalled
        tx_idle_pct = 22;
        rx_idle_pct = 88;
        run_random_phase(RANDOM_PER_PHASE);

        // the other way round
        tx_idle_pct = 88;
        rx_idle_pct = 22;
        run_random_phase(RANDOM_PER_PHASE);

        // full rate, opened by the long receiver hold-off
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold_armed = 1'b1;
        run_random_phase(RANDOM_PER_PHASE);
        in_valid <= 1'b0;

        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lca_pkg.sv
hw/rtl/lca_row_rule.sv
hw/rtl/life_cellular_automaton_unit.sv
dv/tb.sv
